@@ design/llcp_pkg.sv @@
// ----------------------------------------------------------------------------
// llcp_pkg : coordinate parser shared definitions
// character codes, error codes, parse phases and the job record that
// travels from the front end to the back end
// ----------------------------------------------------------------------------
`default_nettype none

package llcp_pkg;

   localparam int VALUE_W = 27;
   localparam int DEG_W   = 21;
   localparam int MIN_W   = 8;
   localparam int ERR_W   = 3;
   localparam int COUNT_W = 4;

   // character codes
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_N = 8'h4E;
   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_W = 8'h57;
   localparam logic [7:0] CHAR_E = 8'h45;

   // token lengths
   localparam logic [COUNT_W-1:0] LEN_SHORT = 4'd7;
   localparam logic [COUNT_W-1:0] LEN_LONG  = 4'd11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   // parse phases
   localparam logic [1:0] PH_LAT   = 2'd0;
   localparam logic [1:0] PH_LON   = 2'd1;
   localparam logic [1:0] PH_TRAIL = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_LENGTH  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NO_NS   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NO_WE   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_LAT_BAD = 3'd4;
   localparam logic [ERR_W-1:0] ERR_LON_BAD = 3'd5;

   // ceil(2^32 / 100): exact quotient for any 27-bit dividend
   localparam int DIV_SHIFT = 32;
   localparam int DIV_MULT_W = 26;
   localparam logic [DIV_MULT_W-1:0] DIV100_MULT = 26'd42949673;
   localparam int PROD_W = VALUE_W + DIV_MULT_W;
   localparam logic [VALUE_W-1:0] HUNDRED = 27'd100;

   typedef struct packed {
      logic [ERR_W-1:0]   error_code;
      logic [VALUE_W-1:0] lat_value;
      logic [VALUE_W-1:0] lon_value;
      logic               lat_neg;
      logic               lon_neg;
      logic               long_form;
   } llcp_job_type;

endpackage

`default_nettype wire

@@ design/llcp_front.sv @@
// ----------------------------------------------------------------------------
// llcp_front : character front end
// classifies each character, accumulates the two decimal values and
// issues one job record at the last character of a token
// ----------------------------------------------------------------------------
`default_nettype none

module llcp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_char_code,
   input  wire logic                req_last_char,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output llcp_pkg::llcp_job_type   push_job
);
   import llcp_pkg::*;

   logic [COUNT_W-1:0] char_count_ff, char_count_in;
   logic [1:0]         phase_ff, phase_in;
   logic [VALUE_W-1:0] lat_value_ff, lat_value_in;
   logic [VALUE_W-1:0] lon_value_ff, lon_value_in;
   logic [COUNT_W-1:0] lat_digits_ff, lat_digits_in;
   logic [COUNT_W-1:0] lon_digits_ff, lon_digits_in;
   logic               lat_south_ff, lat_south_in;
   logic               lon_west_ff, lon_west_in;
   logic               lat_bad_ff, lat_bad_in;
   logic               lon_bad_ff, lon_bad_in;

   logic               is_digit;
   logic [VALUE_W-1:0] digit_val;
   logic               accept;
   logic [ERR_W-1:0]   err;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign is_digit  = (req_char_code >= CHAR_0) && (req_char_code <= CHAR_9);
   assign digit_val = VALUE_W'(req_char_code - CHAR_0);

   always_comb begin
      char_count_in = (char_count_ff == COUNT_MAX) ? COUNT_MAX : char_count_ff + 1'b1;
      phase_in      = phase_ff;
      lat_value_in  = lat_value_ff;
      lon_value_in  = lon_value_ff;
      lat_digits_in = lat_digits_ff;
      lon_digits_in = lon_digits_ff;
      lat_south_in  = lat_south_ff;
      lon_west_in   = lon_west_ff;
      lat_bad_in    = lat_bad_ff;
      lon_bad_in    = lon_bad_ff;
      case (phase_ff)
         PH_LAT: begin
            if (req_char_code == CHAR_N || req_char_code == CHAR_S) begin
               lat_south_in = (req_char_code == CHAR_S);
               phase_in     = PH_LON;
            end else if (is_digit) begin
               // times ten as shift and add, wraps in the accumulator width
               lat_value_in = (lat_value_ff << 3) + (lat_value_ff << 1) + digit_val;
               if (lat_digits_ff != COUNT_MAX) lat_digits_in = lat_digits_ff + 1'b1;
            end else begin
               lat_bad_in = 1'b1;
            end
         end
         PH_LON: begin
            if (req_char_code == CHAR_W || req_char_code == CHAR_E) begin
               lon_west_in = (req_char_code == CHAR_W);
               phase_in    = PH_TRAIL;
            end else if (is_digit) begin
               lon_value_in = (lon_value_ff << 3) + (lon_value_ff << 1) + digit_val;
               if (lon_digits_ff != COUNT_MAX) lon_digits_in = lon_digits_ff + 1'b1;
            end else begin
               lon_bad_in = 1'b1;
            end
         end
         default: begin
            // trailing characters are ignored
         end
      endcase
   end

   // checks in order of precedence
   always_comb begin
      if (char_count_in != LEN_SHORT && char_count_in != LEN_LONG) err = ERR_LENGTH;
      else if (phase_in == PH_LAT)                                err = ERR_NO_NS;
      else if (phase_in == PH_LON)                                err = ERR_NO_WE;
      else if (lat_bad_in || lat_digits_in == '0)                 err = ERR_LAT_BAD;
      else if (lon_bad_in || lon_digits_in == '0)                 err = ERR_LON_BAD;
      else                                                        err = ERR_OK;
   end

   always_comb begin
      push_valid         = accept && req_last_char;
      push_job.error_code = err;
      push_job.long_form  = (char_count_in == LEN_LONG);
      if (err == ERR_OK) begin
         push_job.lat_value = lat_value_in;
         push_job.lon_value = lon_value_in;
         push_job.lat_neg   = lat_south_in;
         push_job.lon_neg   = lon_west_in;
      end else begin
         // zero values give zero fields downstream
         push_job.lat_value = '0;
         push_job.lon_value = '0;
         push_job.lat_neg   = 1'b0;
         push_job.lon_neg   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_char)) begin
         char_count_ff <= '0;
         phase_ff      <= PH_LAT;
         lat_value_ff  <= '0;
         lon_value_ff  <= '0;
         lat_digits_ff <= '0;
         lon_digits_ff <= '0;
         lat_south_ff  <= 1'b0;
         lon_west_ff   <= 1'b0;
         lat_bad_ff    <= 1'b0;
         lon_bad_ff    <= 1'b0;
      end else if (accept) begin
         char_count_ff <= char_count_in;
         phase_ff      <= phase_in;
         lat_value_ff  <= lat_value_in;
         lon_value_ff  <= lon_value_in;
         lat_digits_ff <= lat_digits_in;
         lon_digits_ff <= lon_digits_in;
         lat_south_ff  <= lat_south_in;
         lon_west_ff   <= lon_west_in;
         lat_bad_ff    <= lat_bad_in;
         lon_bad_ff    <= lon_bad_in;
      end
   end

endmodule

`default_nettype wire

@@ design/llcp_queue.sv @@
// ----------------------------------------------------------------------------
// llcp_queue : job queue
// small register queue between the front end and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module llcp_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire llcp_pkg::llcp_job_type push_job,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output llcp_pkg::llcp_job_type pop_job
);
   import llcp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   llcp_job_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

@@ design/llcp_back.sv @@
// ----------------------------------------------------------------------------
// llcp_back : result back end
// splits both values into degrees and minutes by reciprocal multiply for a
// long token, applies the sign and holds the result in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module llcp_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   output logic                        job_ready,
   input  wire llcp_pkg::llcp_job_type job,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_error_code,
   output logic signed [20:0]          rsp_lat_degrees,
   output logic signed [7:0]           rsp_lat_minutes,
   output logic signed [20:0]          rsp_lon_degrees,
   output logic signed [7:0]           rsp_lon_minutes
);
   import llcp_pkg::*;

   typedef struct packed {
      logic [ERR_W-1:0]   error_code;
      logic [DEG_W-1:0]   lat_quot;
      logic [VALUE_W-1:0] lat_mag;
      logic [DEG_W-1:0]   lon_quot;
      logic [VALUE_W-1:0] lon_mag;
      logic               lat_neg;
      logic               lon_neg;
      logic               long_form;
   } llcp_split_type;

   llcp_split_type     split_ff, split_in;
   logic               split_valid_ff;
   logic               out_free, split_free;
   logic [PROD_W-1:0]  lat_prod, lon_prod;

   logic [DEG_W-1:0]   lat_deg_mag, lon_deg_mag;
   logic [MIN_W-1:0]   lat_min_mag, lon_min_mag;
   logic [VALUE_W-1:0] lat_rem, lon_rem;

   logic [ERR_W-1:0]   err_ff;
   logic [DEG_W-1:0]   lat_deg_ff, lat_deg_in, lon_deg_ff, lon_deg_in;
   logic [MIN_W-1:0]   lat_min_ff, lat_min_in, lon_min_ff, lon_min_in;
   logic               rsp_valid_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign split_free = !split_valid_ff || out_free;
   assign job_ready  = split_free;

   // stage one: quotient by 100
   assign lat_prod = PROD_W'(job.lat_value) * PROD_W'(DIV100_MULT);
   assign lon_prod = PROD_W'(job.lon_value) * PROD_W'(DIV100_MULT);

   always_comb begin
      split_in.error_code = job.error_code;
      split_in.lat_quot   = lat_prod[DIV_SHIFT +: DEG_W];
      split_in.lat_mag    = job.lat_value;
      split_in.lon_quot   = lon_prod[DIV_SHIFT +: DEG_W];
      split_in.lon_mag    = job.lon_value;
      split_in.lat_neg    = job.lat_neg;
      split_in.lon_neg    = job.lon_neg;
      split_in.long_form  = job.long_form;
   end

   // stage two: remainder, form select and sign
   always_comb begin
      lat_rem = split_ff.lat_mag - VALUE_W'(split_ff.lat_quot) * HUNDRED;
      lon_rem = split_ff.lon_mag - VALUE_W'(split_ff.lon_quot) * HUNDRED;
      if (split_ff.long_form) begin
         lat_deg_mag = split_ff.lat_quot;
         lon_deg_mag = split_ff.lon_quot;
         lat_min_mag = lat_rem[MIN_W-1:0];
         lon_min_mag = lon_rem[MIN_W-1:0];
      end else begin
         lat_deg_mag = split_ff.lat_mag[DEG_W-1:0];
         lon_deg_mag = split_ff.lon_mag[DEG_W-1:0];
         lat_min_mag = '0;
         lon_min_mag = '0;
      end
      lat_deg_in = split_ff.lat_neg ? -lat_deg_mag : lat_deg_mag;
      lon_deg_in = split_ff.lon_neg ? -lon_deg_mag : lon_deg_mag;
      lat_min_in = split_ff.lat_neg ? -lat_min_mag : lat_min_mag;
      lon_min_in = split_ff.lon_neg ? -lon_min_mag : lon_min_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (split_free) split_valid_ff <= job_valid;
         if (out_free)   rsp_valid_ff   <= split_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (split_free && job_valid) split_ff <= split_in;
      if (out_free && split_valid_ff) begin
         err_ff     <= split_ff.error_code;
         lat_deg_ff <= lat_deg_in;
         lat_min_ff <= lat_min_in;
         lon_deg_ff <= lon_deg_in;
         lon_min_ff <= lon_min_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_lat_degrees = $signed(lat_deg_ff);
   assign rsp_lat_minutes = $signed(lat_min_ff);
   assign rsp_lon_degrees = $signed(lon_deg_ff);
   assign rsp_lon_minutes = $signed(lon_min_ff);

endmodule

`default_nettype wire

@@ design/latlon_coordinate_parser_core.sv @@
// ----------------------------------------------------------------------------
// latlon_coordinate_parser_core : flight plan coordinate token parser
// takes a token such as 5530N03730E one character per item and gives
// latitude and longitude in signed degrees and minutes with an error code
// ----------------------------------------------------------------------------
// usage
//   req channel: one character per item, req_last_char on the final one
//   rsp channel: exactly one item per token, none for inner characters
//   characters are taken at one per cycle, back to back, across tokens, while req_ready is high
//   after the last character is accepted, a result passes through the job
//   queue and the divide stage register, then the output register; the two
//   reciprocal multipliers of the divide stage set the clock, the character
//   accumulate sets the rate
//   a stalled rsp side fills the output register, the divide stage and
//   the job queue; req_ready then drops only when the queue is full
//   reset clears the partial token, the queue and all valid flags
//   any error gives zero in all four value fields
// ----------------------------------------------------------------------------
`default_nettype none

module latlon_coordinate_parser_core #(
   parameter int QUEUE_DEPTH = 2   // jobs held between front and back, 2 to 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_char_code,
   input  wire logic                req_last_char,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_error_code,
   output logic signed [20:0]       rsp_lat_degrees,
   output logic signed [7:0]        rsp_lat_minutes,
   output logic signed [20:0]       rsp_lon_degrees,
   output logic signed [7:0]        rsp_lon_minutes
);
   import llcp_pkg::*;

   // front to queue
   logic         push_valid, push_ready;
   llcp_job_type push_job;
   // queue to back
   logic         pop_valid, pop_ready;
   llcp_job_type pop_job;

   // classify and accumulate, one job per token
   llcp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   // decouples the character stream from result stalls
   llcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // degrees and minutes split, sign, output register
   llcp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (pop_valid),
      .job_ready       (pop_ready),
      .job             (pop_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_error_code  (rsp_error_code),
      .rsp_lat_degrees (rsp_lat_degrees),
      .rsp_lat_minutes (rsp_lat_minutes),
      .rsp_lon_degrees (rsp_lon_degrees),
      .rsp_lon_minutes (rsp_lon_minutes)
   );

endmodule

`default_nettype wire
